// ===== design/kdkf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kdkf_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam int KEY_W  = 4;
    localparam int PINS_W = 16;
    localparam int KEYS   = 12;

    localparam logic [KEYS-1:0] KEY_MASK = 12'hFFF;
    localparam logic [PINS_W-1:0] PINS_RESET = 16'hFFFF;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Pin index to key code and back: Y sits on pin 10, N on pin 11.
    localparam logic [KEY_W-1:0] BIT_TO_CODE [KEYS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd11, 4'd10
    };

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] code;
    } t_dec;

    typedef struct packed {
        logic accept;
        logic exec;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic t_dec decode_keys(input logic [KEYS-1:0] low);
        t_dec d;
        d.hit  = 1'b0;
        d.code = '0;
        for (int i = 0; i < KEYS; i++) begin
            if (low == (KEY_MASK ^ (KEYS'(1) << i))) begin
                d.hit  = 1'b1;
                d.code = BIT_TO_CODE[i];
            end
        end
        return d;
    endfunction

    function automatic logic [KEYS-1:0] key_pattern(input logic [KEY_W-1:0] code);
        logic [KEYS-1:0] p;
        p = KEY_MASK;
        for (int i = 0; i < KEYS; i++) begin
            if (BIT_TO_CODE[i] == code) begin
                p = KEY_MASK ^ (KEYS'(1) << i);
            end
        end
        return p;
    endfunction

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/kdkf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdkf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire kdkf_pkg::t_status i_status,
    output kdkf_pkg::t_cmd        o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.exec, o_cmd.load}))
        else $error("more than one command at once");

    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_cmd.accept) |=> o_cmd.exec)
        else $error("accepted word not executed");

endmodule

`default_nettype wire

// ===== design/kdkf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdkf_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire kdkf_pkg::t_cmd                 i_cmd,
    output kdkf_pkg::t_status                   o_status,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic [kdkf_pkg::PINS_W-1:0]    i_raw_pins,
    input  wire logic [kdkf_pkg::KEY_W-1:0]     i_query_key,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic [kdkf_pkg::KEY_W-1:0]          o_key_code,
    output logic                                o_key_valid,
    output logic                                o_key_captured,
    output logic                                o_fifo_nonempty,
    output logic                                o_any_key_down,
    output logic                                o_key_down_match
);

    logic [kdkf_pkg::KEY_W-1:0]  r_mem [kdkf_pkg::FIFO_DEPTH];
    logic [kdkf_pkg::KEY_W-1:0]  r_rd_data;

    logic [1:0]                  r_op;
    logic [kdkf_pkg::PINS_W-1:0] r_pins;
    logic [kdkf_pkg::KEY_W-1:0]  r_qkey;

    logic [kdkf_pkg::PINS_W-1:0] r_prev;
    logic [kdkf_pkg::PINS_W-1:0] n_prev;
    logic [kdkf_pkg::PTR_W-1:0]  r_wp;
    logic [kdkf_pkg::PTR_W-1:0]  n_wp;
    logic [kdkf_pkg::PTR_W-1:0]  r_rp;
    logic [kdkf_pkg::PTR_W-1:0]  n_rp;

    logic                        r_res_pop;
    logic                        n_res_pop;
    logic [kdkf_pkg::KEY_W-1:0]  r_res_code;
    logic [kdkf_pkg::KEY_W-1:0]  n_res_code;
    logic                        r_res_valid;
    logic                        n_res_valid;
    logic                        r_res_captured;
    logic                        n_res_captured;
    logic                        r_res_any;
    logic                        n_res_any;
    logic                        r_res_match;
    logic                        n_res_match;

    logic                        r_out_valid;
    logic [kdkf_pkg::KEY_W-1:0]  r_key_code;
    logic                        r_key_valid;
    logic                        r_key_captured;
    logic                        r_fifo_nonempty;
    logic                        r_any_key_down;
    logic                        r_key_down_match;

    kdkf_pkg::t_dec              dec;
    logic [kdkf_pkg::KEYS-1:0]   low;
    logic                        any;
    logic                        empty;
    logic                        full;
    logic                        push;

    assign low   = r_pins[kdkf_pkg::KEYS-1:0];
    assign dec   = kdkf_pkg::decode_keys(low);
    assign any   = (low != kdkf_pkg::KEY_MASK);
    assign empty = (r_wp == r_rp);
    assign full  = (kdkf_pkg::next_slot(r_wp) == r_rp);

    always_comb begin
        n_prev         = r_prev;
        n_wp           = r_wp;
        n_rp           = r_rp;
        push           = 1'b0;
        n_res_pop      = 1'b0;
        n_res_code     = '0;
        n_res_valid    = 1'b0;
        n_res_captured = 1'b0;
        n_res_any      = 1'b0;
        n_res_match    = 1'b0;
        unique case (r_op)
            kdkf_pkg::OP_SAMPLE: begin
                n_res_any = any;
                if (r_pins != r_prev) begin
                    n_prev = r_pins;
                    if (dec.hit) begin
                        n_res_code  = dec.code;
                        n_res_valid = 1'b1;
                        if (!full) begin
                            push           = i_cmd.exec;
                            n_wp           = kdkf_pkg::next_slot(r_wp);
                            n_res_captured = 1'b1;
                        end
                    end
                end
            end
            kdkf_pkg::OP_POP: begin
                if (!empty) begin
                    n_res_pop   = 1'b1;
                    n_res_valid = 1'b1;
                    n_rp        = kdkf_pkg::next_slot(r_rp);
                end
            end
            kdkf_pkg::OP_QUERY: begin
                n_res_any = any;
                if (r_qkey < kdkf_pkg::KEY_W'(kdkf_pkg::KEYS)) begin
                    n_res_match = (low == kdkf_pkg::key_pattern(r_qkey));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_opcode;
            r_pins <= i_raw_pins;
            r_qkey <= i_query_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= dec.code;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= kdkf_pkg::PINS_RESET;
            r_wp   <= '0;
            r_rp   <= '0;
        end else if (i_cmd.exec) begin
            r_prev <= n_prev;
            r_wp   <= n_wp;
            r_rp   <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_pop      <= n_res_pop;
            r_res_code     <= n_res_code;
            r_res_valid    <= n_res_valid;
            r_res_captured <= n_res_captured;
            r_res_any      <= n_res_any;
            r_res_match    <= n_res_match;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_code       <= r_res_pop ? r_rd_data : r_res_code;
            r_key_valid      <= r_res_valid;
            r_key_captured   <= r_res_captured;
            r_fifo_nonempty  <= !empty;
            r_any_key_down   <= r_res_any;
            r_key_down_match <= r_res_match;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_key_code       = r_key_code;
    assign o_key_valid      = r_key_valid;
    assign o_key_captured   = r_key_captured;
    assign o_fifo_nonempty  = r_fifo_nonempty;
    assign o_any_key_down   = r_any_key_down;
    assign o_key_down_match = r_key_down_match;

    a_capture_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && r_res_captured) |-> (r_wp != r_rp))
        else $error("captured key left the fifo empty");

    a_pop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_cmd.exec && r_op == kdkf_pkg::OP_POP && r_wp != r_rp)
        |=> (r_rp != $past(r_rp)))
        else $error("pop did not advance read pointer");

    a_sample_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_cmd.exec && r_op == kdkf_pkg::OP_SAMPLE)
        |=> (r_prev == $past(r_pins)))
        else $error("sample not stored as previous pins");

endmodule

`default_nettype wire

// ===== design/keypad_decode_key_fifo.sv =====
// Keypad decoder with a key queue. Each word carries an opcode: a pin sample
// (decoded and queued when it differs from the last stored sample and shows
// exactly one key down), a pop of the oldest queued key, or a query of the
// current pins. The queue has kdkf_pkg::FIFO_DEPTH slots and holds one key
// fewer; keys that arrive when it is full are dropped. Every word gives one
// result word. A word passes from acceptance to the result register in three
// steps (accept, execute, load); the key store is read into a register in the
// execute step, and the load waits while a held result is stalled.
// Input is stalled while a word is in flight; a finished result may wait in
// the output register while the next word is accepted and executed.
`timescale 1ns / 1ps
`default_nettype none

module keypad_decode_key_fifo (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic [kdkf_pkg::PINS_W-1:0]    i_raw_pins,
    input  wire logic [kdkf_pkg::KEY_W-1:0]     i_query_key,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [kdkf_pkg::KEY_W-1:0]          o_key_code,
    output logic                                o_key_valid,
    output logic                                o_key_captured,
    output logic                                o_fifo_nonempty,
    output logic                                o_any_key_down,
    output logic                                o_key_down_match
);

    kdkf_pkg::t_cmd    cmd;
    kdkf_pkg::t_status status;

    kdkf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kdkf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_opcode         (i_opcode),
        .i_raw_pins       (i_raw_pins),
        .i_query_key      (i_query_key),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_key_code       (o_key_code),
        .o_key_valid      (o_key_valid),
        .o_key_captured   (o_key_captured),
        .o_fifo_nonempty  (o_fifo_nonempty),
        .o_any_key_down   (o_any_key_down),
        .o_key_down_match (o_key_down_match)
    );

endmodule

`default_nettype wire

// ===== dv/keypad_decode_key_fifo_tb.sv =====
`timescale 1ns / 1ps

module keypad_decode_key_fifo_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [kdkf_pkg::KEY_W-1:0] KEY_N = 4'd10;
    localparam logic [kdkf_pkg::KEY_W-1:0] KEY_Y = 4'd11;
    localparam int RANDOM_WORDS = 160;

    typedef struct packed {
        logic [kdkf_pkg::KEY_W-1:0] code;
        logic                       valid;
        logic                       captured;
        logic                       nonempty;
        logic                       any;
        logic                       match;
    } t_key_result;

    class key_board;
        logic [kdkf_pkg::KEY_W-1:0]  key_slots [kdkf_pkg::FIFO_DEPTH];
        logic [kdkf_pkg::PTR_W-1:0]  wr_ptr;
        logic [kdkf_pkg::PTR_W-1:0]  rd_ptr;
        logic [kdkf_pkg::PINS_W-1:0] last_stored;
        t_key_result                 expected_words [$];
        int errors;
        int keys_queued;
        int keys_dropped;
        int keys_popped;

        function new();
            wr_ptr       = '0;
            rd_ptr       = '0;
            last_stored  = kdkf_pkg::PINS_RESET;
            errors       = 0;
            keys_queued  = 0;
            keys_dropped = 0;
            keys_popped  = 0;
        endfunction

        static function int pin_of_key(logic [kdkf_pkg::KEY_W-1:0] k);
            int p;
            if (k == KEY_N) begin
                p = 11;
            end else if (k == KEY_Y) begin
                p = 10;
            end else begin
                p = int'(k);
            end
            return p;
        endfunction

        static function logic [kdkf_pkg::KEY_W-1:0] key_of_pin(int p);
            logic [kdkf_pkg::KEY_W-1:0] k;
            if (p == 10) begin
                k = KEY_Y;
            end else if (p == 11) begin
                k = KEY_N;
            end else begin
                k = kdkf_pkg::KEY_W'(p);
            end
            return k;
        endfunction

        function logic [kdkf_pkg::PTR_W-1:0] advance(logic [kdkf_pkg::PTR_W-1:0] p);
            return kdkf_pkg::PTR_W'((int'(p) + 1) % kdkf_pkg::FIFO_DEPTH);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_word(logic [1:0] op, logic [kdkf_pkg::PINS_W-1:0] pins,
                                logic [kdkf_pkg::KEY_W-1:0] qk);
            t_key_result                r;
            logic [kdkf_pkg::KEYS-1:0]  low;
            logic [kdkf_pkg::PTR_W-1:0] nxt;
            logic                       hit;
            logic [kdkf_pkg::KEY_W-1:0] k;
            r   = '0;
            low = pins[kdkf_pkg::KEYS-1:0];
            hit = 1'b0;
            k   = '0;
            case (op)
                kdkf_pkg::OP_SAMPLE: begin
                    r.any = (low != kdkf_pkg::KEY_MASK);
                    if (pins != last_stored) begin
                        for (int i = 0; i < kdkf_pkg::KEYS; i++) begin
                            if (low == (kdkf_pkg::KEY_MASK
                                        ^ (kdkf_pkg::KEYS'(1) << i))) begin
                                hit = 1'b1;
                                k   = key_of_pin(i);
                            end
                        end
                        if (hit) begin
                            r.code  = k;
                            r.valid = 1'b1;
                            nxt     = advance(wr_ptr);
                            if (nxt != rd_ptr) begin
                                key_slots[wr_ptr] = k;
                                wr_ptr            = nxt;
                                r.captured        = 1'b1;
                                keys_queued++;
                            end else begin
                                keys_dropped++;
                            end
                        end
                        last_stored = pins;
                    end
                end
                kdkf_pkg::OP_POP: begin
                    if (wr_ptr != rd_ptr) begin
                        r.code  = key_slots[rd_ptr];
                        r.valid = 1'b1;
                        rd_ptr  = advance(rd_ptr);
                        keys_popped++;
                    end
                end
                kdkf_pkg::OP_QUERY: begin
                    r.any = (low != kdkf_pkg::KEY_MASK);
                    if (int'(qk) < kdkf_pkg::KEYS) begin
                        r.match = (low == (kdkf_pkg::KEY_MASK
                                           ^ (kdkf_pkg::KEYS'(1) << pin_of_key(qk))));
                    end
                end
                default: begin
                end
            endcase
            r.nonempty = (wr_ptr != rd_ptr);
            expected_words.push_back(r);
        endfunction

        function void compare_field(string name, logic [kdkf_pkg::KEY_W-1:0] want,
                                    logic [kdkf_pkg::KEY_W-1:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_word(t_key_result got);
            t_key_result want;
            if (expected_words.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_words.pop_front();
                compare_field("key_code", want.code, got.code);
                compare_field("key_valid", 4'(want.valid), 4'(got.valid));
                compare_field("key_captured", 4'(want.captured), 4'(got.captured));
                compare_field("fifo_nonempty", 4'(want.nonempty), 4'(got.nonempty));
                compare_field("any_key_down", 4'(want.any), 4'(got.any));
                compare_field("key_down_match", 4'(want.match), 4'(got.match));
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [1:0]                    i_opcode;
    logic [kdkf_pkg::PINS_W-1:0]   i_raw_pins;
    logic [kdkf_pkg::KEY_W-1:0]    i_query_key;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [kdkf_pkg::KEY_W-1:0]    o_key_code;
    logic                          o_key_valid;
    logic                          o_key_captured;
    logic                          o_fifo_nonempty;
    logic                          o_any_key_down;
    logic                          o_key_down_match;

    key_board                      board = new();
    t_key_result                   got;
    int                            send_idle = 35;
    int                            recv_idle = 66;
    int                            words_sent = 0;
    logic [kdkf_pkg::PINS_W-1:0]   last_pins = kdkf_pkg::PINS_RESET;
    logic                          key_held = 1'b0;

    keypad_decode_key_fifo dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_raw_pins       (i_raw_pins),
        .i_query_key      (i_query_key),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_key_code       (o_key_code),
        .o_key_valid      (o_key_valid),
        .o_key_captured   (o_key_captured),
        .o_fifo_nonempty  (o_fifo_nonempty),
        .o_any_key_down   (o_any_key_down),
        .o_key_down_match (o_key_down_match)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_word(i_opcode, i_raw_pins, i_query_key);
            end
            if (o_out_valid && !i_out_stall) begin
                got.code     = o_key_code;
                got.valid    = o_key_valid;
                got.captured = o_key_captured;
                got.nonempty = o_fifo_nonempty;
                got.any      = o_any_key_down;
                got.match    = o_key_down_match;
                board.check_word(got);
            end
        end
    end

    task automatic send_word(input logic [1:0] op,
                             input logic [kdkf_pkg::PINS_W-1:0] pins,
                             input logic [kdkf_pkg::KEY_W-1:0] qk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_raw_pins  <= pins;
        i_query_key <= qk;
        if (op == kdkf_pkg::OP_SAMPLE) begin
            last_pins = pins;
        end
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_random_word(input int pop_pct);
        logic [1:0]                  op;
        logic [kdkf_pkg::PINS_W-1:0] pins;
        logic [kdkf_pkg::KEY_W-1:0]  qk;
        logic [3:0]                  upper;
        int                          pin;
        int                          pick;
        op    = kdkf_pkg::OP_POP;
        pins  = kdkf_pkg::PINS_W'($urandom);
        qk    = kdkf_pkg::KEY_W'($urandom_range(15));
        upper = ($urandom_range(3) == 0) ? 4'($urandom) : 4'hF;
        pin   = $urandom_range(kdkf_pkg::KEYS - 1);
        if ($urandom_range(99) >= pop_pct) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                op = kdkf_pkg::OP_SAMPLE;
                if (key_held) begin
                    pins = {upper, kdkf_pkg::KEY_MASK};
                end else begin
                    pins = {upper, kdkf_pkg::KEY_MASK ^ (kdkf_pkg::KEYS'(1) << pin)};
                end
                key_held = !key_held;
            end else if (pick < 68) begin
                op = kdkf_pkg::OP_SAMPLE;
                case ($urandom_range(2))
                    0: pins = last_pins;
                    1: pins[kdkf_pkg::KEYS-1:0] = kdkf_pkg::KEY_MASK
                           ^ (kdkf_pkg::KEYS'(1) << pin)
                           ^ (kdkf_pkg::KEYS'(1) << ((pin + 1) % kdkf_pkg::KEYS));
                    default: begin
                    end
                endcase
            end else if (pick < 93) begin
                op = kdkf_pkg::OP_QUERY;
                if ($urandom_range(1) == 1) begin
                    pins = {upper, kdkf_pkg::KEY_MASK ^ (kdkf_pkg::KEYS'(1) << pin)};
                    if ($urandom_range(1) == 1) begin
                        qk = key_board::key_of_pin(pin);
                    end
                end
            end else begin
                op = OP_UNUSED;
            end
        end
        send_word(op, pins, qk);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= kdkf_pkg::OP_SAMPLE;
        i_raw_pins  <= kdkf_pkg::PINS_RESET;
        i_query_key <= '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(kdkf_pkg::OP_SAMPLE, 16'hFFFF, 4'd0);
        send_word(kdkf_pkg::OP_POP, 16'h0000, 4'd15);
        send_word(kdkf_pkg::OP_SAMPLE, 16'h0000, 4'd0);
        send_word(kdkf_pkg::OP_QUERY, 16'h0000, 4'd0);
        send_word(kdkf_pkg::OP_SAMPLE, 16'h0FFF, 4'd0);
        send_word(kdkf_pkg::OP_QUERY,
                  {4'hF, kdkf_pkg::KEY_MASK ^ (kdkf_pkg::KEYS'(1) << 10)}, KEY_Y);
        send_word(kdkf_pkg::OP_QUERY,
                  {4'hF, kdkf_pkg::KEY_MASK ^ (kdkf_pkg::KEYS'(1) << 11)}, 4'd15);
        send_word(OP_UNUSED, 16'h5A5A, 4'd12);
        for (int i = 0; i < kdkf_pkg::FIFO_DEPTH; i++) begin
            send_word(kdkf_pkg::OP_SAMPLE,
                      {4'(i), kdkf_pkg::KEY_MASK
                              ^ (kdkf_pkg::KEYS'(1) << (i % kdkf_pkg::KEYS))},
                      4'd0);
        end
        send_word(kdkf_pkg::OP_SAMPLE, last_pins, 4'd0);
        drain_results();

        send_idle = 35;
        recv_idle = 66;
        repeat (RANDOM_WORDS) send_random_word(20);
        drain_results();

        send_idle = 66;
        recv_idle = 35;
        repeat (RANDOM_WORDS) send_random_word(8);
        drain_results();

        send_idle = 0;
        recv_idle = 0;
        repeat (RANDOM_WORDS) send_random_word(30);
        drain_results();

        repeat (20) @(negedge i_clk);
        $display("Sent %0d words: samples, pops, queries and unused opcodes.", words_sent);
        $display("Keys queued %0d, dropped when full %0d, popped %0d.",
                 board.keys_queued, board.keys_dropped, board.keys_popped);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
